FILE: hw/rtl/rylap_pkg.sv
// Package for the RGB to YUV luma adjust pipeline.
// Holds the pixel word types shared by the stream interfaces and the top level,
// plus the fixed-point conversion coefficients. No dependencies.
`default_nettype none

package rylap_pkg;

   // Source pixel word.
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       end_of_frame;
   } req_word_type;

   // Converted and adjusted pixel word.
   typedef struct packed {
      logic [7:0] luma_gray;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_word_type;

   // Width of the product sums; every sum in the datapath fits in 18 signed bits.
   localparam int unsigned SUM_W = 18;

   // Forward coefficients, 8.8 fixed point.
   localparam logic signed [SUM_W-1:0] COEF_Y_R = 18'sd77;
   localparam logic signed [SUM_W-1:0] COEF_Y_G = 18'sd150;
   localparam logic signed [SUM_W-1:0] COEF_Y_B = 18'sd29;
   localparam logic signed [SUM_W-1:0] COEF_U_R = -18'sd44;
   localparam logic signed [SUM_W-1:0] COEF_U_G = -18'sd87;
   localparam logic signed [SUM_W-1:0] COEF_U_B = 18'sd131;
   localparam logic signed [SUM_W-1:0] COEF_V_R = 18'sd131;
   localparam logic signed [SUM_W-1:0] COEF_V_G = -18'sd110;
   localparam logic signed [SUM_W-1:0] COEF_V_B = -18'sd21;

   // Inverse coefficients, 8.8 fixed point.
   localparam logic signed [SUM_W-1:0] COEF_R_V = 18'sd360;
   localparam logic signed [SUM_W-1:0] COEF_G_U = 18'sd88;
   localparam logic signed [SUM_W-1:0] COEF_G_V = 18'sd184;
   localparam logic signed [SUM_W-1:0] COEF_B_U = 18'sd455;

   // Chroma midpoint.
   localparam logic signed [9:0] CHROMA_BIAS = 10'sd128;

endpackage : rylap_pkg

`default_nettype wire

FILE: hw/rtl/rylap_req_if.sv
// Stream interface carrying source pixel words into the pipeline.
// Depends on rylap_pkg for the word type.
`default_nettype none

interface rylap_req_if;
   import rylap_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface : rylap_req_if

`default_nettype wire

FILE: hw/rtl/rylap_rsp_if.sv
// Stream interface carrying converted pixel words out of the pipeline.
// Depends on rylap_pkg for the word type.
`default_nettype none

interface rylap_rsp_if;
   import rylap_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface : rylap_rsp_if

`default_nettype wire

FILE: hw/rtl/rgb_yuv_luma_adjust_pipeline.sv
// RGB to YUV conversion with brightness adjust and RGB reconstruction, four stages.
// One pixel word enters per clock while the output is not stalled; its result passes
// through the four register stages (forward products, floor shift and saturation,
// inverse products, final sum and saturation) in that order. Each stage holds its
// word while the stage after it is full and cannot move on, so back-pressure on the
// output costs no words. The luma offset is read in the second stage; write it only
// while the pipeline is empty. Depends on rylap_pkg, rylap_req_if and rylap_rsp_if.
`default_nettype none

module rgb_yuv_luma_adjust_pipeline (
   input  wire logic       clock,
   input  wire logic       reset,
   rylap_req_if.sink       req_chan,
   rylap_rsp_if.source     rsp_chan,
   input  wire logic       csr_write,
   input  wire logic [8:0] csr_wdata
);
   import rylap_pkg::*;

   // Clamp a signed value to 0..255.
   function automatic logic [7:0] sat8(input logic signed [10:0] value);
      logic [7:0] res;
      if (value < 0) begin
         res = 8'd0;
      end else if (value > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = value[7:0];
      end
      return res;
   endfunction

   // Luma offset register.
   logic signed [8:0] luma_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_offset_ff <= '0;
      end else if (csr_write) begin
         luma_offset_ff <= $signed(csr_wdata);
      end
   end

   // Stage registers.
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                    s1_ready, s2_ready, s3_ready, s4_ready;
   logic signed [SUM_W-1:0] s1_y_sum_ff, s1_u_sum_ff, s1_v_sum_ff;
   logic                    s1_eof_ff;
   logic [7:0]              s2_ya_ff, s2_u_ff, s2_v_ff;
   logic                    s2_eof_ff;
   logic [7:0]              s3_ya_ff, s3_u_ff, s3_v_ff;
   logic signed [SUM_W-1:0] s3_r_prod_ff, s3_g_prod_ff, s3_b_prod_ff;
   logic                    s3_eof_ff;
   rsp_word_type            s4_word_ff;

   // A stage may load when it is empty or its word moves on this cycle.
   assign s4_ready = !s4_valid_ff || rsp_chan.ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_chan.ready = s1_ready;
   assign rsp_chan.valid = s4_valid_ff;
   assign rsp_chan.data  = s4_word_ff;

   // Stage 1 logic: forward product sums.
   logic signed [SUM_W-1:0] red_s, green_s, blue_s;
   logic signed [SUM_W-1:0] y_sum_in, u_sum_in, v_sum_in;

   always_comb begin
      red_s    = $signed({{(SUM_W-8){1'b0}}, req_chan.data.red_in});
      green_s  = $signed({{(SUM_W-8){1'b0}}, req_chan.data.green_in});
      blue_s   = $signed({{(SUM_W-8){1'b0}}, req_chan.data.blue_in});
      y_sum_in = COEF_Y_R * red_s + COEF_Y_G * green_s + COEF_Y_B * blue_s;
      u_sum_in = COEF_U_R * red_s + COEF_U_G * green_s + COEF_U_B * blue_s;
      v_sum_in = COEF_V_R * red_s + COEF_V_G * green_s + COEF_V_B * blue_s;
   end

   // Stage 2 logic: floor shift, chroma bias, luma offset and saturation.
   logic signed [9:0]  y_shift, u_shift, v_shift;
   logic signed [10:0] ya_sum, u_biased, v_biased;
   logic [7:0]         ya_in, u_in, v_in;

   always_comb begin
      y_shift  = 10'(s1_y_sum_ff >>> 8);
      u_shift  = 10'(s1_u_sum_ff >>> 8);
      v_shift  = 10'(s1_v_sum_ff >>> 8);
      ya_sum   = 11'(y_shift) + 11'(luma_offset_ff);
      u_biased = 11'(u_shift) + 11'(CHROMA_BIAS);
      v_biased = 11'(v_shift) + 11'(CHROMA_BIAS);
      ya_in    = sat8(ya_sum);
      u_in     = sat8(u_biased);
      v_in     = sat8(v_biased);
   end

   // Stage 3 logic: inverse products on the centered chroma.
   logic signed [SUM_W-1:0] du, dv;
   logic signed [SUM_W-1:0] r_prod_in, g_prod_in, b_prod_in;

   always_comb begin
      du        = $signed({{(SUM_W-8){1'b0}}, s2_u_ff}) - SUM_W'(CHROMA_BIAS);
      dv        = $signed({{(SUM_W-8){1'b0}}, s2_v_ff}) - SUM_W'(CHROMA_BIAS);
      r_prod_in = COEF_R_V * dv;
      g_prod_in = COEF_G_U * du + COEF_G_V * dv;
      b_prod_in = COEF_B_U * du;
   end

   // Stage 4 logic: floor shift, add adjusted luma and saturate.
   logic signed [10:0] ya_s, r_sum, g_sum, b_sum;
   rsp_word_type       word_in;

   always_comb begin
      ya_s                = $signed({3'b000, s3_ya_ff});
      r_sum               = ya_s + 11'(s3_r_prod_ff >>> 8);
      g_sum               = ya_s - 11'(s3_g_prod_ff >>> 8);
      b_sum               = ya_s + 11'(s3_b_prod_ff >>> 8);
      word_in.luma_gray   = s3_ya_ff;
      word_in.chroma_u    = s3_u_ff;
      word_in.chroma_v    = s3_v_ff;
      word_in.red_out     = sat8(r_sum);
      word_in.green_out   = sat8(g_sum);
      word_in.blue_out    = sat8(b_sum);
      word_in.frame_end   = s3_eof_ff;
   end

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Payload registers load whenever their stage is free.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_y_sum_ff <= y_sum_in;
         s1_u_sum_ff <= u_sum_in;
         s1_v_sum_ff <= v_sum_in;
         s1_eof_ff   <= req_chan.data.end_of_frame;
      end
      if (s2_ready) begin
         s2_ya_ff  <= ya_in;
         s2_u_ff   <= u_in;
         s2_v_ff   <= v_in;
         s2_eof_ff <= s1_eof_ff;
      end
      if (s3_ready) begin
         s3_ya_ff     <= s2_ya_ff;
         s3_u_ff      <= s2_u_ff;
         s3_v_ff      <= s2_v_ff;
         s3_r_prod_ff <= r_prod_in;
         s3_g_prod_ff <= g_prod_in;
         s3_b_prod_ff <= b_prod_in;
         s3_eof_ff    <= s2_eof_ff;
      end
      if (s4_ready) begin
         s4_word_ff <= word_in;
      end
   end

endmodule : rgb_yuv_luma_adjust_pipeline

`default_nettype wire

FILE: verif/rylap_checker.sv
// Scoreboard for the RGB to YUV luma adjust pipeline: watches both streams and the offset
// register port, predicts each output word and compares it field by field.
// Depends on rylap_pkg for the word types.
`timescale 1ns / 100ps

module rylap_checker (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  rylap_pkg::req_word_type req_data,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  rylap_pkg::rsp_word_type rsp_data,
   input  wire logic            csr_write,
   input  wire logic [8:0]      csr_wdata,
   output int unsigned          fail_count,
   output int unsigned          pending_count
);
   import rylap_pkg::*;

   // Local copy of the brightness offset and the words still owed by the block.
   logic signed [8:0] luma_offset_q;
   rsp_word_type      pixel_q[$];
   int unsigned       words_seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      words_seen    = 0;
      luma_offset_q = '0;
   end

   function automatic logic [7:0] clamp_byte(int value);
      if (value < 0) return 8'd0;
      if (value > 255) return 8'd255;
      return value[7:0];
   endfunction

   // Forward transform with floor shifts, offset on luma, then rebuild RGB from the
   // clamped luma and chroma. An arithmetic shift of a signed int is a floor divide.
   function automatic rsp_word_type convert_pixel(req_word_type px, logic signed [8:0] offs);
      int r, g, b, y, du, dv, shift_luma;
      rsp_word_type w;
      r = int'(px.red_in);
      g = int'(px.green_in);
      b = int'(px.blue_in);
      shift_luma = offs;
      y = (77 * r + 150 * g + 29 * b) >>> 8;
      w.chroma_u = clamp_byte(((-44 * r - 87 * g + 131 * b) >>> 8) + 128);
      w.chroma_v = clamp_byte(((131 * r - 110 * g - 21 * b) >>> 8) + 128);
      w.luma_gray = clamp_byte(y + shift_luma);
      du = int'(w.chroma_u) - 128;
      dv = int'(w.chroma_v) - 128;
      w.red_out   = clamp_byte(int'(w.luma_gray) + ((360 * dv) >>> 8));
      w.green_out = clamp_byte(int'(w.luma_gray) - ((88 * du + 184 * dv) >>> 8));
      w.blue_out  = clamp_byte(int'(w.luma_gray) + ((455 * du) >>> 8));
      w.frame_end = px.end_of_frame;
      return w;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("pixel word %0d: %s got %0d, expected %0d", words_seen, field, got, want);
      fail_count++;
   endtask

   // Sample everything at the rising edge, before the block's own registers update.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         luma_offset_q = '0;
         pixel_q.delete();
      end else begin
         if (csr_write) begin
            luma_offset_q = csr_wdata;
         end
         if (req_valid && req_ready) begin
            pixel_q.push_back(convert_pixel(req_data, luma_offset_q));
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data.luma_gray != want.luma_gray)
                  report_mismatch("luma_gray", rsp_data.luma_gray, want.luma_gray);
               if (rsp_data.chroma_u != want.chroma_u)
                  report_mismatch("chroma_u", rsp_data.chroma_u, want.chroma_u);
               if (rsp_data.chroma_v != want.chroma_v)
                  report_mismatch("chroma_v", rsp_data.chroma_v, want.chroma_v);
               if (rsp_data.red_out != want.red_out)
                  report_mismatch("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.green_out != want.green_out)
                  report_mismatch("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.blue_out != want.blue_out)
                  report_mismatch("blue_out", rsp_data.blue_out, want.blue_out);
               if (rsp_data.frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_data.frame_end, want.frame_end);
            end
            words_seen++;
         end
      end
      pending_count = pixel_q.size();
   end

endmodule : rylap_checker

FILE: verif/tb_top.sv
// Top of the luma adjust pipeline testbench: clock, reset, offset writes, pixel stimulus
// with random idling and a long output stall, and the final verdict.
// Depends on rylap_pkg, both stream interfaces, the pipeline and rylap_checker.
`timescale 1ns / 100ps

module tb_top;
   import rylap_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 60;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [8:0]  csr_wdata;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_request;
   bit          hold_off;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count;

   // Primary and secondary colors: the extremes of every channel and the chroma overflows.
   logic [23:0] corner_rgb [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                   24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00};

   rylap_req_if req_chan ();
   rylap_rsp_if rsp_chan ();

   rgb_yuv_luma_adjust_pipeline dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   rylap_checker pixel_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Output side: random back-pressure, overridden by the long hold-off.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Long output stall, counted on its own so the sender keeps pushing into a full pipe.
   initial begin
      hold_off = 1'b0;
      wait (hold_request);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Offers one word, with random idle cycles first; called and returns at a falling edge.
   task automatic push_pixel(input req_word_type px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= px;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_offset(input logic [8:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly uniform pixels, plus saturated channels and near-gray pixels.
   function automatic req_word_type random_pixel();
      req_word_type px;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      px.red_in   = 8'($urandom);
      px.green_in = 8'($urandom);
      px.blue_in  = 8'($urandom);
      if (pick < 15) begin
         px.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (pick < 30) begin
         px.green_in = px.red_in ^ 8'($urandom_range(0, 3));
         px.blue_in  = px.red_in ^ 8'($urandom_range(0, 3));
      end
      px.end_of_frame = ($urandom_range(0, 15) == 0);
      return px;
   endfunction

   task automatic run_random(input int unsigned count, input int unsigned sender_idle,
                             input int unsigned receiver_idle, input logic [8:0] offset);
      write_offset(offset);
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      repeat (count) push_pixel(random_pixel());
      req_chan.valid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      req_word_type px;
      logic [8:0]   directed_offset [3];
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_request   = 1'b0;
      directed_offset = '{9'h000, 9'h0FF, 9'h100};

      // Hold reset, then release it at a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Corner colors at no offset, the largest boost and the largest cut.
      for (int k = 0; k < 3; k++) begin
         write_offset(directed_offset[k]);
         for (int i = 0; i < 8; i++) begin
            px.red_in       = corner_rgb[i][23:16];
            px.green_in     = corner_rgb[i][15:8];
            px.blue_in      = corner_rgb[i][7:0];
            px.end_of_frame = i[0] ^ k[0];
            push_pixel(px);
         end
         req_chan.valid <= 1'b0;
         wait_drained();
      end

      run_random(216, 36, 86, 9'($urandom_range(0, 511)));
      run_random(216, 86, 36, 9'($urandom_range(0, 511)));

      // No idling, with one long output stall at the start.
      hold_request = 1'b1;
      run_random(218, 0, 0, 9'(int'($urandom_range(0, 80)) - 40));

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule : tb_top
